[hw/rtl/pfdg_pkg.sv]
// Shared types, frame geometry and luma helper for the palette downscaler.
// No dependencies.
package pfdg_pkg;

    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 200;
    localparam int OUT_WIDTH  = 128;
    localparam int OUT_HEIGHT = 80;

    localparam int SC_W = $clog2(SRC_WIDTH);
    localparam int SR_W = $clog2(SRC_HEIGHT);
    localparam int PC_W = $clog2(SRC_WIDTH + 1);
    localparam int PR_W = $clog2(SRC_HEIGHT + 1);
    localparam int DC_W = $clog2(OUT_WIDTH + 1);
    localparam int DR_W = $clog2(OUT_HEIGHT + 1);

    localparam int COL_STEP = SRC_WIDTH / OUT_WIDTH;
    localparam int COL_REM  = SRC_WIDTH % OUT_WIDTH;
    localparam int ROW_STEP = SRC_HEIGHT / OUT_HEIGHT;
    localparam int ROW_REM  = SRC_HEIGHT % OUT_HEIGHT;

    localparam int COORD_W = 7;
    localparam int GRAY_W  = 4;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [GRAY_W-1:0] gray_t;

    typedef struct packed {
        logic               sel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               row_end;
        logic               frame_end;
    } pick_t;

    function automatic gray_t luma_nibble(input logic [COLOR_W-1:0] color);
        logic [15:0] sum;
        sum = 16'(color[23:16]) * 16'(LUMA_R) + 16'(color[15:8]) * 16'(LUMA_G)
            + 16'(color[7:0]) * 16'(LUMA_B);
        return sum[15:12];
    endfunction

endpackage

[hw/rtl/pfdg_luma_ram.sv]
// 256 x 4 gray lookup memory, one write and one registered read port.
// Per-entry valid bits give the all-zero reset contents. Uses pfdg_pkg.
module pfdg_luma_ram (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  pfdg_pkg::idx_t  wr_addr,
    input  pfdg_pkg::gray_t wr_data,
    input  logic            rd_en,
    input  pfdg_pkg::idx_t  rd_addr,
    output pfdg_pkg::gray_t rd_data
);
    import pfdg_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    gray_t            mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    gray_t            q_reg;
    logic             q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

[hw/rtl/pfdg_scaler.sv]
// Source/destination raster counters and nearest-neighbor pick logic.
// Advances once per source pixel transfer. Uses pfdg_pkg.
module pfdg_scaler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    output pfdg_pkg::pick_t pick
);
    import pfdg_pkg::*;

    logic [SC_W-1:0] src_col_reg, src_col_next;
    logic [SR_W-1:0] src_row_reg, src_row_next;
    logic [DC_W-1:0] dst_col_reg, dst_col_next;
    logic [DR_W-1:0] dst_row_reg, dst_row_next;
    logic [PC_W-1:0] pick_col_reg, pick_col_next;
    logic [PR_W-1:0] pick_row_reg, pick_row_next;
    logic [DC_W-1:0] col_frac_reg, col_frac_next;
    logic [DR_W-1:0] row_frac_reg, row_frac_next;

    logic          row_sel;
    logic          col_sel;
    logic [DC_W:0] col_sum;
    logic [DR_W:0] row_sum;
    logic          col_carry;
    logic          row_carry;

    assign row_sel = (PR_W'(src_row_reg) == pick_row_reg)
                   && (dst_row_reg < DR_W'(OUT_HEIGHT));
    assign col_sel = (PC_W'(src_col_reg) == pick_col_reg)
                   && (dst_col_reg < DC_W'(OUT_WIDTH));

    assign col_sum   = {1'b0, col_frac_reg} + (DC_W+1)'(COL_REM);
    assign row_sum   = {1'b0, row_frac_reg} + (DR_W+1)'(ROW_REM);
    assign col_carry = col_sum >= (DC_W+1)'(OUT_WIDTH);
    assign row_carry = row_sum >= (DR_W+1)'(OUT_HEIGHT);

    always_comb
    begin
        pick.sel       = row_sel && col_sel;
        pick.col       = COORD_W'(dst_col_reg);
        pick.row       = COORD_W'(dst_row_reg);
        pick.row_end   = dst_col_reg == DC_W'(OUT_WIDTH - 1);
        pick.frame_end = pick.row_end && (dst_row_reg == DR_W'(OUT_HEIGHT - 1));
    end

    always_comb
    begin
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        dst_col_next  = dst_col_reg;
        dst_row_next  = dst_row_reg;
        pick_col_next = pick_col_reg;
        pick_row_next = pick_row_reg;
        col_frac_next = col_frac_reg;
        row_frac_next = row_frac_reg;
        if (row_sel && col_sel)
        begin
            dst_col_next  = dst_col_reg + 1'b1;
            pick_col_next = pick_col_reg + PC_W'(COL_STEP) + PC_W'(col_carry);
            col_frac_next = col_carry ? DC_W'(col_sum - (DC_W+1)'(OUT_WIDTH))
                                      : DC_W'(col_sum);
        end
        if (src_col_reg == SC_W'(SRC_WIDTH - 1))
        begin
            src_col_next  = '0;
            dst_col_next  = '0;
            pick_col_next = '0;
            col_frac_next = '0;
            if (row_sel)
            begin
                dst_row_next  = dst_row_reg + 1'b1;
                pick_row_next = pick_row_reg + PR_W'(ROW_STEP) + PR_W'(row_carry);
                row_frac_next = row_carry ? DR_W'(row_sum - (DR_W+1)'(OUT_HEIGHT))
                                          : DR_W'(row_sum);
            end
            if (src_row_reg == SR_W'(SRC_HEIGHT - 1))
            begin
                src_row_next  = '0;
                dst_row_next  = '0;
                pick_row_next = '0;
                row_frac_next = '0;
            end
            else
            begin
                src_row_next = src_row_reg + 1'b1;
            end
        end
        else
        begin
            src_col_next = src_col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            pick_col_reg <= '0;
            pick_row_reg <= '0;
            col_frac_reg <= '0;
            row_frac_reg <= '0;
        end
        else if (adv)
        begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            dst_col_reg  <= dst_col_next;
            dst_row_reg  <= dst_row_next;
            pick_col_reg <= pick_col_next;
            pick_row_reg <= pick_row_next;
            col_frac_reg <= col_frac_next;
            row_frac_reg <= row_frac_next;
        end
    end

endmodule

[hw/rtl/palette_frame_downscale_to_gray4.sv]
// Top level: palette write / pixel stream in, downscaled 4-bit gray stream out.
// Depends on pfdg_pkg, pfdg_luma_ram, pfdg_scaler.
//
//  channel   | dir | tdata                                   | tuser     | tlast
//  s_axis    | in  | palette_index, palette_color, src_pixel | mode      | -
//  m_axis    | out | out_col, out_row, gray_level            | frame_end | row_end
//
// One s_axis transfer per clock sustained while m_axis_tready stays high; a picked
// pixel reaches m_axis through the table read stage, then the output register.
// The table read stage and the output register form a two-entry pipeline; with
// m_axis holding a transfer and m_axis_tready low, an occupied read stage holds
// and s_axis_tready drops.
// Reset clears counters and table valid bits at once; no clearing pass.
module palette_frame_downscale_to_gray4 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] palette_index, [31:8] palette_color, [39:32] source_pixel
    input  logic [pfdg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [6:0] out_col, [13:7] out_row, [17:14] gray_level, [23:18] zero
    output logic [pfdg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] frame_end
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import pfdg_pkg::*;

    logic  accept;
    logic  pix_adv;
    logic  hit;
    logic  wr_en;
    logic  s1_adv;
    pick_t pick;
    gray_t rd_gray;

    logic  s1_vld_reg;
    pick_t s1_meta_reg;
    logic  m_vld_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic  m_last_reg;
    logic  m_user_reg;

    assign s1_adv        = s1_vld_reg && (!m_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pix_adv       = accept && (s_axis_tuser == MODE_PIXEL);
    assign wr_en         = accept && (s_axis_tuser == MODE_PALETTE);
    assign hit           = pix_adv && pick.sel;

    pfdg_scaler u_scaler (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (pix_adv),
        .pick  (pick)
    );

    pfdg_luma_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (s_axis_tdata[IDX_W-1:0]),
        .wr_data (luma_nibble(s_axis_tdata[IDX_W+COLOR_W-1:IDX_W])),
        .rd_en   (hit),
        .rd_addr (s_axis_tdata[IDX_W+COLOR_W+IDX_W-1:IDX_W+COLOR_W]),
        .rd_data (rd_gray)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end
        else
        begin
            if (hit)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                m_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            s1_meta_reg <= pick;
        end
        if (s1_adv)
        begin
            m_data_reg <= OUT_TDATA_W'({rd_gray, s1_meta_reg.row, s1_meta_reg.col});
            m_last_reg <= s1_meta_reg.row_end;
            m_user_reg <= s1_meta_reg.frame_end;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

[hw/rtl/pfdg_checker.sv]
// Port-level checks for palette_frame_downscale_to_gray4, bound to the top.
// Uses pfdg_pkg.
module pfdg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pfdg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);
    import pfdg_pkg::*;

    logic [COORD_W-1:0] col;
    assign col = m_axis_tdata[COORD_W-1:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
        else $error("frame end without row end");

    a_row_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (col == COORD_W'(OUT_WIDTH - 1))))
        else $error("row end mark does not match last column");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:2*COORD_W+GRAY_W] == '0))
        else $error("tdata padding not zero");

endmodule

bind palette_frame_downscale_to_gray4 pfdg_checker u_pfdg_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for palette_frame_downscale_to_gray4: palette writes and
// pixel streams in, gray transfers checked against a built-in downscale predictor.
// Depends on pfdg_pkg and the palette_frame_downscale_to_gray4 RTL.
module tb_top;
    import pfdg_pkg::*;

    localparam int ITEM_TOTAL     = 1200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RESET_CYCLES   = 7;
    localparam int WRITE_PCT      = 5;

    typedef struct packed {
        logic               mode;
        idx_t               idx;
        logic [COLOR_W-1:0] color;
        idx_t               pix;
    } pal_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        gray_t              gray;
        logic               row_end;
        logic               frame_end;
    } gray_px_t;

    typedef struct packed {
        pal_item_t item;
        logic      typed;
        logic      emits;
        gray_px_t  px;
    } dir_row_t;

    localparam gray_px_t NO_PX = '0;

    // typed rows: reset table, full-white and black entries, unselected column
    localparam dir_row_t DIR_TAB [21] = '{
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'hFF}, 1'b1, 1'b1,
          '{7'd0, 7'd0, 4'd0, 1'b0, 1'b0}},
        '{'{MODE_PALETTE, 8'hFF, 24'hFFFFFF, 8'h00}, 1'b1, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'h00, 24'h000000, 8'hFF}, 1'b1, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'h80, 24'hFF0000, 8'h55}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'h01, 24'h00FF00, 8'hAA}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'h7F, 24'h0000FF, 8'h00}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'h55, 24'h123456, 8'h80}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'hAA, 24'hEDCBA9, 8'h7F}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'hFF, 24'hFFFFFF, 8'h00}, 1'b1, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'hAA, 24'h5A5A5A, 8'hFF}, 1'b1, 1'b1,
          '{7'd1, 7'd0, 4'd15, 1'b0, 1'b0}},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h80}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h80}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h80}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h01}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h7F}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h55}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PALETTE, 8'hFF, 24'h000000, 8'hFF}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'hFF}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'hAA}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h00}, 1'b0, 1'b0, NO_PX},
        '{'{MODE_PIXEL,   8'h00, 24'h000000, 8'h7F}, 1'b0, 1'b0, NO_PX}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_count    = 0;
    int stall_cycles = 0;

    gray_px_t gray_expect_q[$];

    // predictor state
    gray_t             luma_shadow [256];
    logic [SC_W-1:0]   src_col_q;
    logic [SR_W-1:0]   src_row_q;
    logic [DC_W-1:0]   dst_col_q;
    logic [DR_W-1:0]   dst_row_q;
    logic [PC_W-1:0]   pick_col_q;
    logic [DC_W-1:0]   col_frac_q;
    logic [PR_W-1:0]   pick_row_q;
    logic [DR_W-1:0]   row_frac_q;

    palette_frame_downscale_to_gray4 u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic bit downscale_step(input pal_item_t it, output gray_px_t px);
        int  luma;
        bit  row_sel;
        bit  col_sel;
        bit  emit;
        emit = 1'b0;
        px   = '0;
        if (it.mode == MODE_PALETTE)
        begin
            luma = (int'(it.color[23:16]) * 77 + int'(it.color[15:8]) * 150
                  + int'(it.color[7:0]) * 29) >> 8;
            luma_shadow[it.idx] = luma[7:4];
            return 1'b0;
        end
        row_sel = (src_row_q == pick_row_q) && (dst_row_q < OUT_HEIGHT);
        col_sel = (src_col_q == pick_col_q) && (dst_col_q < OUT_WIDTH);
        if (row_sel && col_sel)
        begin
            px.col       = dst_col_q[COORD_W-1:0];
            px.row       = dst_row_q[COORD_W-1:0];
            px.gray      = luma_shadow[it.pix];
            px.row_end   = (dst_col_q == OUT_WIDTH - 1);
            px.frame_end = px.row_end && (dst_row_q == OUT_HEIGHT - 1);
            emit         = 1'b1;
            dst_col_q    = dst_col_q + 1'b1;
            pick_col_q   = pick_col_q + PC_W'(COL_STEP);
            col_frac_q   = col_frac_q + DC_W'(COL_REM);
            if (col_frac_q >= OUT_WIDTH)
            begin
                col_frac_q = col_frac_q - DC_W'(OUT_WIDTH);
                pick_col_q = pick_col_q + 1'b1;
            end
        end
        if (src_col_q >= SRC_WIDTH - 1)
        begin
            src_col_q  = '0;
            dst_col_q  = '0;
            pick_col_q = '0;
            col_frac_q = '0;
            if (row_sel)
            begin
                dst_row_q  = dst_row_q + 1'b1;
                pick_row_q = pick_row_q + PR_W'(ROW_STEP);
                row_frac_q = row_frac_q + DR_W'(ROW_REM);
                if (row_frac_q >= OUT_HEIGHT)
                begin
                    row_frac_q = row_frac_q - DR_W'(OUT_HEIGHT);
                    pick_row_q = pick_row_q + 1'b1;
                end
            end
            if (src_row_q >= SRC_HEIGHT - 1)
            begin
                src_row_q  = '0;
                dst_row_q  = '0;
                pick_row_q = '0;
                row_frac_q = '0;
            end
            else
            begin
                src_row_q = src_row_q + 1'b1;
            end
        end
        else
        begin
            src_col_q = src_col_q + 1'b1;
        end
        return emit;
    endfunction

    // drive one item and return right after the edge that accepts it
    task automatic send_item(input pal_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.pix, it.color, it.idx};
        s_axis_tuser  <= it.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        gray_px_t got;
        gray_px_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tdata[17:14],
                    m_axis_tlast, m_axis_tuser};
            if (gray_expect_q.size() == 0)
            begin
                $display("%0t: unexpected transfer col=%0d row=%0d gray=%0d last=%0b user=%0b",
                         $time, got.col, got.row, got.gray, got.row_end, got.frame_end);
                err_count++;
            end
            else
            begin
                want = gray_expect_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected col=%0d row=%0d gray=%0d last=%0b user=%0b",
                             $time, want.col, want.row, want.gray, want.row_end,
                             want.frame_end);
                    $display("%0t:          actual   col=%0d row=%0d gray=%0d last=%0b user=%0b",
                             $time, got.col, got.row, got.gray, got.row_end, got.frame_end);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        pal_item_t it;
        gray_px_t  px;
        bit        emit;
        int        item_sent;

        foreach (luma_shadow[i])
            luma_shadow[i] = '0;
        src_col_q  = '0;
        src_row_q  = '0;
        dst_col_q  = '0;
        dst_row_q  = '0;
        pick_col_q = '0;
        col_frac_q = '0;
        pick_row_q = '0;
        row_frac_q = '0;
        item_sent  = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[i])
        begin
            send_item(DIR_TAB[i].item);
            emit = downscale_step(DIR_TAB[i].item, px);
            if (DIR_TAB[i].typed)
            begin
                if (DIR_TAB[i].emits)
                    gray_expect_q.push_back(DIR_TAB[i].px);
            end
            else if (emit)
            begin
                gray_expect_q.push_back(px);
            end
            item_sent++;
        end

        // random part covers the first source rows, picked and skipped
        while (item_sent < ITEM_TOTAL)
        begin
            case (item_sent * 4 / ITEM_TOTAL)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            it.mode  = ($urandom_range(0, 99) < WRITE_PCT) ? MODE_PALETTE : MODE_PIXEL;
            it.idx   = idx_t'($urandom);
            it.color = COLOR_W'($urandom);
            it.pix   = idx_t'($urandom);
            if (it.mode == MODE_PALETTE && $urandom_range(0, 7) == 0)
                it.color = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            send_item(it);
            if (downscale_step(it, px))
                gray_expect_q.push_back(px);
            item_sent++;
        end
        s_axis_tvalid <= 1'b0;
        rx_stall_pct = 0;

        while (gray_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
